FILE: design/bdq_pkg.sv
package bdq_pkg;

    localparam int CAP_W = 11;
    localparam int DATA_W = 32;
    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [2:0] CMD_POP_BACK   = 3'd3;
    localparam logic [2:0] CMD_NOP        = 3'd4;

    localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_CAP  = 3'b100
    } state_t;

endpackage

FILE: design/bdq_ram.sv
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    output logic [WIDTH-1:0] rdata_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

FILE: design/bounded_double_ended_queue_top.sv
// An accepted input beat is applied in ST_IDLE; the front and rear entries
// are read through the registered RAM ports in ST_READ, and the result is
// captured in ST_CAP. No new input beat is taken until the state is ST_IDLE.
// The next input beat is taken while a result waits in the output register.
// Reset (rst_n low, asynchronous): queue empty, head 0, capacity 1024.
// Entry RAM contents are not cleared; no clearing pass is needed.
module bounded_double_ended_queue_top #(
    parameter int DEPTH = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bdq_pkg::CAP_W-1:0]            capacity,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [2:0]                           command,
    input  logic signed [bdq_pkg::DATA_W-1:0]    value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 success,
    output logic signed [bdq_pkg::DATA_W-1:0]    front_value,
    output logic signed [bdq_pkg::DATA_W-1:0]    rear_value,
    output logic                                 empty_flag,
    output logic                                 full_flag
);

    import bdq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1) > 0 ? $clog2(DEPTH + 1) : 1;
    localparam int SW = AW + 1;
    localparam int WW = (CW > CAP_W) ? CW : CAP_W;
    localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
    localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);
    localparam logic [WW-1:0] DEPTH_W = WW'(DEPTH);

    state_t state_reg, state_next;
    logic [CAP_W-1:0] cap_reg;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic success_reg, success_next;

    logic out_valid_reg;
    logic signed [DATA_W-1:0] front_reg, rear_reg;
    logic empty_reg, full_reg;
    logic success_out_reg;

    logic [WW-1:0] cap_eff;
    logic [WW-1:0] count_w;
    logic [AW-1:0] head_dec, head_inc;
    logic [SW-1:0] back_sum, rear_sum;
    logic [AW-1:0] back_pos, rear_pos;
    logic accept, can_push, can_pop, load_out;
    logic we;
    logic [AW-1:0] waddr;
    logic [DATA_W-1:0] rd_front, rd_rear;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign load_out  = (state_reg == ST_CAP) && (!out_valid_reg || out_ready);

    always_comb
    begin
        cap_eff = WW'(cap_reg);
        if (cap_reg == '0)
        begin
            cap_eff = WW'(1);
        end
        else if (WW'(cap_reg) > DEPTH_W)
        begin
            cap_eff = DEPTH_W;
        end
    end

    assign count_w  = WW'(count_reg);
    assign can_push = (count_w < cap_eff);
    assign can_pop  = (count_reg != '0);

    assign head_dec = (head_reg == '0) ? LAST_POS : head_reg - AW'(1);
    assign head_inc = (head_reg == LAST_POS) ? '0 : head_reg + AW'(1);

    assign back_sum = SW'(head_reg) + SW'(count_reg);
    assign back_pos = (back_sum >= DEPTH_S) ? AW'(back_sum - DEPTH_S) : AW'(back_sum);
    assign rear_sum = SW'(head_reg) + SW'(count_reg) - SW'(1);
    assign rear_pos = (rear_sum >= DEPTH_S) ? AW'(rear_sum - DEPTH_S) : AW'(rear_sum);

    always_comb
    begin
        head_next    = head_reg;
        count_next   = count_reg;
        success_next = success_reg;
        we           = 1'b0;
        waddr        = back_pos;
        state_next   = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    success_next = 1'b0;
                    state_next   = ST_READ;
                    if (command inside {CMD_PUSH_FRONT, CMD_PUSH_BACK})
                    begin
                        if (can_push)
                        begin
                            we           = 1'b1;
                            success_next = 1'b1;
                            count_next   = count_reg + CW'(1);
                            if (command == CMD_PUSH_FRONT)
                            begin
                                waddr     = head_dec;
                                head_next = head_dec;
                            end
                        end
                    end
                    else if (command inside {CMD_POP_FRONT, CMD_POP_BACK})
                    begin
                        if (can_pop)
                        begin
                            success_next = 1'b1;
                            count_next   = count_reg - CW'(1);
                            if (command == CMD_POP_FRONT)
                            begin
                                head_next = head_inc;
                            end
                        end
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_CAP;
            end
            ST_CAP:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    bdq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (value),
        .raddr_a (head_reg),
        .rdata_a (rd_front),
        .raddr_b (rear_pos),
        .rdata_b (rd_rear)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_reg       <= CAP_RESET;
            head_reg      <= '0;
            count_reg     <= '0;
            success_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            success_reg <= success_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= capacity;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            success_out_reg <= success_reg;
            empty_reg       <= !can_pop;
            full_reg        <= !can_push;
            if (can_pop)
            begin
                front_reg <= rd_front;
                rear_reg  <= rd_rear;
            end
            else
            begin
                front_reg <= EMPTY_VALUE;
                rear_reg  <= EMPTY_VALUE;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign success     = success_out_reg;
    assign front_value = front_reg;
    assign rear_value  = rear_reg;
    assign empty_flag  = empty_reg;
    assign full_flag   = full_reg;

endmodule

FILE: design/bdq_checker.sv
module bdq_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic                              success,
    input logic signed [bdq_pkg::DATA_W-1:0] front_value,
    input logic signed [bdq_pkg::DATA_W-1:0] rear_value,
    input logic                              empty_flag,
    input logic                              full_flag
);

    import bdq_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(front_value)
            && $stable(rear_value) && $stable(success))
        else $error("result beat changed while stalled");

    a_empty_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && empty_flag |-> front_value == EMPTY_VALUE
            && rear_value == EMPTY_VALUE)
        else $error("empty result without marker values");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(empty_flag && full_flag))
        else $error("empty and full at once");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready)
        else $error("input beat taken while an item is in flight");

endmodule

bind bounded_double_ended_queue_top bdq_checker u_bdq_checker (.*);

FILE: tb/sv/bdq_result_checker.sv
module bdq_result_checker #(
    parameter int DEPTH = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [bdq_pkg::CAP_W-1:0]         capacity,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic [2:0]                        command,
    input  logic signed [bdq_pkg::DATA_W-1:0] value,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic                              success,
    input  logic signed [bdq_pkg::DATA_W-1:0] front_value,
    input  logic signed [bdq_pkg::DATA_W-1:0] rear_value,
    input  logic                              empty_flag,
    input  logic                              full_flag,
    output int                                mismatches,
    output int                                pending,
    output int                                results_seen
);

    typedef struct packed {
        logic                              ok;
        logic signed [bdq_pkg::DATA_W-1:0] front;
        logic signed [bdq_pkg::DATA_W-1:0] rear;
        logic                              empty;
        logic                              full;
    } deque_view_t;

    logic signed [bdq_pkg::DATA_W-1:0] ring [DEPTH];
    int                                head_pos;
    int                                occupancy;
    logic [bdq_pkg::CAP_W-1:0]         cap_setting;
    deque_view_t                       awaited_views [$];
    deque_view_t                       want;
    deque_view_t                       got;
    int                                err_total;
    int                                seen_total;

    function automatic deque_view_t apply_command(input logic [2:0] cmd,
                                                  input logic signed [31:0] val);
        deque_view_t r;
        int          limit;
        limit = (cap_setting == 0) ? 1 : ((cap_setting > DEPTH) ? DEPTH : int'(cap_setting));
        r.ok = 1'b0;
        case (cmd)
            bdq_pkg::CMD_PUSH_FRONT, bdq_pkg::CMD_PUSH_BACK:
            begin
                if (occupancy < limit)
                begin
                    if (cmd == bdq_pkg::CMD_PUSH_FRONT)
                    begin
                        head_pos = (head_pos + DEPTH - 1) % DEPTH;
                        ring[head_pos] = val;
                    end
                    else
                    begin
                        ring[(head_pos + occupancy) % DEPTH] = val;
                    end
                    occupancy++;
                    r.ok = 1'b1;
                end
            end
            bdq_pkg::CMD_POP_FRONT, bdq_pkg::CMD_POP_BACK:
            begin
                if (occupancy > 0)
                begin
                    if (cmd == bdq_pkg::CMD_POP_FRONT)
                    begin
                        head_pos = (head_pos + 1) % DEPTH;
                    end
                    occupancy--;
                    r.ok = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        if (occupancy == 0)
        begin
            r.front = bdq_pkg::EMPTY_VALUE;
            r.rear  = bdq_pkg::EMPTY_VALUE;
        end
        else
        begin
            r.front = ring[head_pos];
            r.rear  = ring[(head_pos + occupancy - 1) % DEPTH];
        end
        r.empty = (occupancy == 0);
        r.full  = (occupancy >= limit);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_pos     = 0;
            occupancy    = 0;
            cap_setting  = bdq_pkg::CAP_RESET;
            err_total    = 0;
            seen_total   = 0;
            awaited_views.delete();
            mismatches   <= 0;
            pending      <= 0;
            results_seen <= 0;
        end
        else
        begin
            // compare results before queuing this edge's input beat
            if (out_valid && out_ready)
            begin
                got = '{success, front_value, rear_value, empty_flag, full_flag};
                seen_total++;
                if (awaited_views.size() == 0)
                begin
                    err_total++;
                    if (err_total <= 10)
                        $display("[%0t] result beat with none outstanding: ok=%0b front=%0d rear=%0d",
                                 $time, got.ok, got.front, got.rear);
                end
                else
                begin
                    want = awaited_views.pop_front();
                    if (got !== want)
                    begin
                        err_total++;
                        if (err_total <= 10)
                        begin
                            $display("[%0t] result mismatch #%0d", $time, err_total);
                            $display("    expected ok=%0b front=%0d rear=%0d empty=%0b full=%0b",
                                     want.ok, want.front, want.rear, want.empty, want.full);
                            $display("    actual   ok=%0b front=%0d rear=%0d empty=%0b full=%0b",
                                     got.ok, got.front, got.rear, got.empty, got.full);
                        end
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                cap_setting = capacity;
            if (in_valid && in_ready)
                awaited_views.push_back(apply_command(command, value));
            mismatches   <= err_total;
            pending      <= awaited_views.size();
            results_seen <= seen_total;
        end
    end

endmodule

FILE: tb/sv/bounded_double_ended_queue_top_tb.sv
module bounded_double_ended_queue_top_tb;

    localparam int IDLE_LIMIT = 4000;

    logic                              clk;
    logic                              rst_n;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [bdq_pkg::CAP_W-1:0]         capacity;
    logic                              in_valid;
    logic                              in_ready;
    logic [2:0]                        command;
    logic signed [bdq_pkg::DATA_W-1:0] value;
    logic                              out_valid;
    logic                              out_ready;
    logic                              success;
    logic signed [bdq_pkg::DATA_W-1:0] front_value;
    logic signed [bdq_pkg::DATA_W-1:0] rear_value;
    logic                              empty_flag;
    logic                              full_flag;

    int   mismatches;
    int   pending;
    int   results_seen;
    int   commands_sent;
    int   cap_writes;
    int   stalled_cycles;
    logic quiet;

    bounded_double_ended_queue_top #(.DEPTH(1024)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .capacity    (capacity),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .success     (success),
        .front_value (front_value),
        .rear_value  (rear_value),
        .empty_flag  (empty_flag),
        .full_flag   (full_flag)
    );

    bdq_result_checker #(.DEPTH(1024)) result_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .capacity     (capacity),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .success      (success),
        .front_value  (front_value),
        .rear_value   (rear_value),
        .empty_flag   (empty_flag),
        .full_flag    (full_flag),
        .mismatches   (mismatches),
        .pending      (pending),
        .results_seen (results_seen)
    );

    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        capacity  = bdq_pkg::CAP_RESET;
        in_valid  = 1'b0;
        command   = bdq_pkg::CMD_NOP;
        value     = '0;
        out_ready = 1'b0;
        quiet     = 1'b0;
    end

    always #5 clk = ~clk;

    always @(negedge clk)
        out_ready <= quiet || ($urandom_range(0, 99) >= 23);

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
        if (stalled_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, pending);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_command(input logic [2:0] c, input logic signed [31:0] v);
        @(negedge clk);
        while (!quiet && $urandom_range(0, 99) < 23)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        command  <= c;
        value    <= v;
        do @(posedge clk); while (!in_ready);
        commands_sent++;
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [bdq_pkg::CAP_W-1:0] c);
        settle();
        cfg_valid <= 1'b1;
        capacity  <= c;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cap_writes++;
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'sh7FFFFFFF;
            1:       return 32'sh80000000;
            2:       return -32'sd1;
            3:       return 32'sd0;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_burst(input int n, input int push_pct);
        int          roll;
        logic [2:0]  c;
        for (int i = 0; i < n; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < push_pct)
                c = $urandom_range(0, 1) ? bdq_pkg::CMD_PUSH_BACK : bdq_pkg::CMD_PUSH_FRONT;
            else if (roll < 96)
                c = $urandom_range(0, 1) ? bdq_pkg::CMD_POP_BACK : bdq_pkg::CMD_POP_FRONT;
            else
                c = 3'($urandom_range(bdq_pkg::CMD_NOP, 7));
            send_command(c, pick_value());
        end
    endtask

    initial
    begin
        commands_sent  = 0;
        cap_writes     = 0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // empty queue, extremes, every command code
        send_command(bdq_pkg::CMD_POP_FRONT, 32'sd11);
        send_command(bdq_pkg::CMD_POP_BACK, 32'sd12);
        send_command(bdq_pkg::CMD_PUSH_FRONT, 32'sh7FFFFFFF);
        send_command(bdq_pkg::CMD_PUSH_BACK, 32'sh80000000);
        send_command(bdq_pkg::CMD_PUSH_FRONT, -32'sd1);
        send_command(bdq_pkg::CMD_PUSH_BACK, 32'sd0);
        send_command(bdq_pkg::CMD_NOP, 32'sh5A5A5A5A);
        send_command(3'd5, 32'sh0F0F0F0F);
        send_command(3'd6, 32'shF0F0F0F0);
        send_command(3'd7, 32'sh12345678);
        send_command(bdq_pkg::CMD_POP_FRONT, 32'sd0);
        send_command(bdq_pkg::CMD_POP_BACK, 32'sd0);
        send_command(bdq_pkg::CMD_POP_FRONT, 32'sd0);
        send_command(bdq_pkg::CMD_POP_BACK, 32'sd0);
        send_command(bdq_pkg::CMD_POP_BACK, 32'sd0);

        // single-entry capacity, and zero acting as one
        write_capacity(11'd1);
        send_command(bdq_pkg::CMD_PUSH_BACK, 32'sd5);
        send_command(bdq_pkg::CMD_PUSH_FRONT, 32'sd6);
        send_command(bdq_pkg::CMD_POP_FRONT, 32'sd0);
        write_capacity(11'd0);
        send_command(bdq_pkg::CMD_PUSH_FRONT, 32'sd7);
        send_command(bdq_pkg::CMD_PUSH_BACK, 32'sd8);

        // lower the capacity below the current occupancy
        write_capacity(11'd8);
        for (int i = 0; i < 4; i++)
            send_command(bdq_pkg::CMD_PUSH_BACK, 32'(i + 100));
        write_capacity(11'd2);
        send_command(bdq_pkg::CMD_PUSH_FRONT, 32'sd9);
        send_command(bdq_pkg::CMD_POP_FRONT, 32'sd0);
        send_command(bdq_pkg::CMD_POP_BACK, 32'sd0);

        // fill the ring to its depth with the oversized capacity and push on past it; hold off idling midway
        write_capacity(11'd2047);
        run_burst(450, 94);
        quiet <= 1'b1;
        run_burst(300, 94);
        quiet <= 1'b0;
        run_burst(450, 94);

        write_capacity(11'd3);
        run_burst(100, 10);
        write_capacity(11'd1024);
        run_burst(80, 55);
        write_capacity(11'd16);
        run_burst(70, 45);
        write_capacity(11'd5);
        run_burst(70, 50);
        write_capacity(11'($urandom_range(0, 2047)));
        run_burst(70, 50);
        write_capacity(11'd4);
        run_burst(70, 48);

        settle();
        repeat (8) @(negedge clk);
        $display("Drove %0d commands through %0d capacity settings, up to a full 1024-entry ring.",
                 commands_sent, cap_writes);
        $display("Compared %0d result beats; %0d mismatches, %0d left outstanding.",
                 results_seen, mismatches, pending);
        if (mismatches == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
